[src/fatd_pkg.sv]
package fatd_pkg;

  localparam int unsigned KindW    = 2;
  localparam int unsigned ClusterW = 28;
  localparam int unsigned RawW     = 32;
  localparam int unsigned SectorW  = 32;
  localparam int unsigned OffsetW  = 12;
  localparam int unsigned ClassW   = 3;
  localparam int unsigned TypeW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OverW    = 41;

  typedef enum logic [KindW-1:0] {
    KIND_LOCATE   = 2'd0,
    KIND_CLASSIFY = 2'd1,
    KIND_DATA     = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [TypeW-1:0] {
    VOL_FAT12 = 2'd0,
    VOL_FAT16 = 2'd1,
    VOL_FAT32 = 2'd2
  } vol_type_e;

  typedef enum logic [ClassW-1:0] {
    CLS_FREE     = 3'd0,
    CLS_NEXT     = 3'd1,
    CLS_RESERVED = 3'd2,
    CLS_BAD      = 3'd3,
    CLS_END      = 3'd4,
    CLS_INVALID  = 3'd5
  } entry_class_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SECTOR_LOG2     = 3'd0,
    CFG_CLUSTER_LOG2    = 3'd1,
    CFG_RESERVED        = 3'd2,
    CFG_FAT_COPIES      = 3'd3,
    CFG_SECTORS_PER_FAT = 3'd4,
    CFG_ROOT_ENTRIES    = 3'd5,
    CFG_TOTAL_SECTORS   = 3'd6
  } cfg_idx_e;

  localparam logic [31:0] Fat12Limit = 32'd4085;
  localparam logic [31:0] Fat16Limit = 32'd65525;

  localparam logic [ClusterW-1:0] Base12 = 28'h0000FF0;
  localparam logic [ClusterW-1:0] Base16 = 28'h000FFF0;
  localparam logic [ClusterW-1:0] Base32 = 28'hFFFFFF0;

  typedef struct packed {
    logic [3:0]  sector_log2;
    logic [2:0]  cluster_log2;
    logic [15:0] reserved;
    logic [7:0]  fat_copies;
    logic [31:0] sectors_per_fat;
    logic [15:0] root_entries;
    logic [31:0] total_sectors;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    sector_log2:     4'd9,
    cluster_log2:    3'd0,
    reserved:        16'd1,
    fat_copies:      8'd2,
    sectors_per_fat: 32'd9,
    root_entries:    16'd224,
    total_sectors:   32'd2880
  };

  typedef struct packed {
    logic [31:0] cluster_total;
    logic [31:0] first_data_sector;
    vol_type_e   vol_type;
  } geom_t;

  // value of an entry plus the compares that do not depend on the cluster count
  typedef struct packed {
    logic [ClusterW-1:0] value;
    logic                zero;
    logic                ge2;
    logic                below;
    logic                rsv;
    logic                bad;
    logic                last;
  } entry_t;

  // sector size log2 saturated into 9..12, returned as 0..3
  function automatic logic [1:0] eff_sl2(input logic [3:0] sl);
    logic [1:0] r;
    if (sl < 4'd9) begin
      r = 2'd0;
    end else if (sl > 4'd12) begin
      r = 2'd3;
    end else begin
      r = 2'(sl - 4'd9);
    end
    return r;
  endfunction

  // bytes per sector minus one
  function automatic logic [OffsetW-1:0] sector_mask(input logic [1:0] sl2);
    logic [OffsetW:0] bps;
    bps = (OffsetW+1)'(512) << sl2;
    return OffsetW'(bps - (OffsetW+1)'(1));
  endfunction

endpackage

[src/fatd_geom.sv]
module fatd_geom (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fatd_pkg::cfg_t   cfg_i,
  output fatd_pkg::geom_t  geom_o
);
  import fatd_pkg::*;

  logic [1:0]        sl2;
  logic [21:0]       root_sum;
  logic [39:0]       prod_d, prod_q;
  logic [12:0]       root_d, root_q;
  logic [OverW-1:0]  over_d, over_q;
  logic [31:0]       data;
  logic [31:0]       ct_d, ct_q;
  logic [31:0]       fds_d, fds_q;
  vol_type_e         type_d, type_q;

  // stage one: fat area product and root directory sectors
  always_comb begin
    sl2      = eff_sl2(cfg_i.sector_log2);
    root_sum = {1'b0, cfg_i.root_entries, 5'b0} + 22'(sector_mask(sl2));
    root_d   = 13'(root_sum >> (5'd9 + 5'(sl2)));
    prod_d   = 40'(cfg_i.fat_copies) * 40'(cfg_i.sectors_per_fat);
  end

  // stage two: sectors ahead of the data region
  assign over_d = OverW'(cfg_i.reserved) + OverW'(prod_q) + OverW'(root_q);

  // stage three: cluster count and first data sector
  always_comb begin
    if ({9'b0, cfg_i.total_sectors} > over_q) begin
      data = cfg_i.total_sectors - over_q[31:0];
    end else begin
      data = '0;
    end
    ct_d  = data >> cfg_i.cluster_log2;
    fds_d = (|over_q[OverW-1:32]) ? '1 : over_q[31:0];
  end

  // stage four: fat type
  always_comb begin
    if (ct_q < Fat12Limit) begin
      type_d = VOL_FAT12;
    end else if (ct_q < Fat16Limit) begin
      type_d = VOL_FAT16;
    end else begin
      type_d = VOL_FAT32;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= 40'd18;
      root_q <= 13'd14;
      over_q <= OverW'(33);
      ct_q   <= 32'd2847;
      fds_q  <= 32'd33;
      type_q <= VOL_FAT12;
    end else begin
      prod_q <= prod_d;
      root_q <= root_d;
      over_q <= over_d;
      ct_q   <= ct_d;
      fds_q  <= fds_d;
      type_q <= type_d;
    end
  end

  assign geom_o = '{cluster_total: ct_q, first_data_sector: fds_q, vol_type: type_q};

endmodule

[src/fat_table_entry_locate_decode.sv]
// an item accepted at a clock edge has its result on the ports, with done_o, once it
//   has passed the five register stages incl. the output
// throughput: one item per cycle while busy_o is low, no stall from the receiver
// a configuration write holds busy_o high while the geometry chain re-derives
// reset: pipeline emptied, registers at boot defaults (2880 sectors, 512-byte sectors)
module fat_table_entry_locate_decode (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [fatd_pkg::KindW-1:0]     kind_i,
  input  logic [fatd_pkg::ClusterW-1:0]  cluster_i,
  input  logic [fatd_pkg::RawW-1:0]      raw_entry_i,
  input  logic                           cfg_we_i,
  input  logic [fatd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fatd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                           done_o,
  output logic [fatd_pkg::TypeW-1:0]     volume_type_o,
  output logic [fatd_pkg::SectorW-1:0]   sector_number_o,
  output logic [fatd_pkg::OffsetW-1:0]   byte_offset_o,
  output logic [fatd_pkg::ClassW-1:0]    entry_class_o,
  output logic [fatd_pkg::ClusterW-1:0]  next_cluster_o,
  output logic                           out_of_range_o
);
  import fatd_pkg::*;

  cfg_t        cfg_q;
  geom_t       geom;
  logic [1:0]  settle_q;
  logic [1:0]  sl2;
  logic [OffsetW-1:0] smask;

  // stage 1: captured item
  logic                v1_q;
  kind_e               kind1_q;
  logic [ClusterW-1:0] cl1_q;
  logic [RawW-1:0]     raw1_q;

  // stage 2: offsets and entry values for each fat type
  logic                v2_q;
  kind_e               kind2_q;
  logic [ClusterW-1:0] cl2_q;
  logic [29:0]         off_d [0:2];
  logic [29:0]         off2_q [0:2];
  entry_t              ent_d [0:2];
  entry_t              ent2_q [0:2];

  // stage 3: fat sector and byte offset per type, scaled data cluster
  logic                v3_q;
  kind_e               kind3_q;
  logic [ClusterW-1:0] cl3_q;
  logic [SectorW-1:0]  sect_d [0:2];
  logic [SectorW-1:0]  sect3_q [0:2];
  logic [OffsetW-1:0]  boff_d [0:2];
  logic [OffsetW-1:0]  boff3_q [0:2];
  entry_t              ent3_q [0:2];
  logic [SectorW-1:0]  dsh_d, dsh3_q;

  // stage 4: classes per type, range check, data sector
  logic                v4_q;
  kind_e               kind4_q;
  logic [SectorW-1:0]  sect4_q [0:2];
  logic [OffsetW-1:0]  boff4_q [0:2];
  entry_class_e        cls_d [0:2];
  entry_class_e        cls4_q [0:2];
  logic [ClusterW-1:0] nxt_d [0:2];
  logic [ClusterW-1:0] nxt4_q [0:2];
  logic                oor_d, oor4_q;
  logic [SectorW-1:0]  dsec_d, dsec4_q;

  // stage 5: output register
  logic                v5_q;
  logic [1:0]          tsel;
  logic [SectorW-1:0]  sect5_d, sect5_q;
  logic [OffsetW-1:0]  boff5_d, boff5_q;
  entry_class_e        cls5_d, cls5_q;
  logic [ClusterW-1:0] nxt5_d, nxt5_q;
  vol_type_e           type5_q;
  logic                oor5_q;

  function automatic entry_t make_entry(input logic [ClusterW-1:0] v,
                                        input logic [ClusterW-1:0] base);
    entry_t e;
    e.value = v;
    e.zero  = (v == '0);
    e.ge2   = (v >= ClusterW'(2));
    e.below = (v < base);
    e.rsv   = (v >= base) && (v <= base + ClusterW'(6));
    e.bad   = (v == base + ClusterW'(7));
    e.last  = (v >= base + ClusterW'(8));
    return e;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SECTOR_LOG2:     cfg_q.sector_log2     <= cfg_wdata_i[3:0];
        CFG_CLUSTER_LOG2:    cfg_q.cluster_log2    <= cfg_wdata_i[2:0];
        CFG_RESERVED:        cfg_q.reserved        <= cfg_wdata_i[15:0];
        CFG_FAT_COPIES:      cfg_q.fat_copies      <= cfg_wdata_i[7:0];
        CFG_SECTORS_PER_FAT: cfg_q.sectors_per_fat <= cfg_wdata_i;
        CFG_ROOT_ENTRIES:    cfg_q.root_entries    <= cfg_wdata_i[15:0];
        CFG_TOTAL_SECTORS:   cfg_q.total_sectors   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd0;
    end else if (cfg_we_i) begin
      settle_q <= 2'd3;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  assign busy_o = (settle_q != 2'd0);

  fatd_geom u_geom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .geom_o (geom)
  );

  assign sl2   = eff_sl2(cfg_q.sector_log2);
  assign smask = sector_mask(sl2);

  // stage 1 -> 2
  always_comb begin
    logic [15:0] w;
    w = raw1_q[15:0];
    off_d[0] = 30'(cl1_q) + 30'(cl1_q >> 1);
    off_d[1] = {1'b0, cl1_q, 1'b0};
    off_d[2] = {cl1_q, 2'b00};
    // fat12: odd clusters sit in the upper 12 bits of the 16-bit word
    ent_d[0] = make_entry(ClusterW'(cl1_q[0] ? w[15:4] : w[11:0]), Base12);
    ent_d[1] = make_entry(ClusterW'(w), Base16);
    ent_d[2] = make_entry(raw1_q[ClusterW-1:0], Base32);
  end

  // stage 2 -> 3
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      sect_d[t] = SectorW'(cfg_q.reserved) + SectorW'(off2_q[t] >> (5'd9 + 5'(sl2)));
      boff_d[t] = off2_q[t][OffsetW-1:0] & smask;
    end
    dsh_d = SectorW'(cl2_q - ClusterW'(2)) << cfg_q.cluster_log2;
  end

  // stage 3 -> 4
  always_comb begin
    logic [32:0] lim;
    lim   = {1'b0, geom.cluster_total} + 33'd1;
    oor_d = (cl3_q < ClusterW'(2)) || ({4'b0, cl3_q} > geom.cluster_total);
    dsec_d = geom.first_data_sector + dsh3_q;
    for (int t = 0; t < 3; t++) begin
      nxt_d[t] = '0;
      if (ent3_q[t].zero) begin
        cls_d[t] = CLS_FREE;
      end else if (ent3_q[t].ge2 && ent3_q[t].below &&
                   ({5'b0, ent3_q[t].value} <= lim)) begin
        cls_d[t] = CLS_NEXT;
        nxt_d[t] = ent3_q[t].value;
      end else if (ent3_q[t].rsv) begin
        cls_d[t] = CLS_RESERVED;
      end else if (ent3_q[t].bad) begin
        cls_d[t] = CLS_BAD;
      end else if (ent3_q[t].last) begin
        cls_d[t] = CLS_END;
      end else begin
        cls_d[t] = CLS_INVALID;
      end
    end
  end

  // stage 4 -> 5: pick the volume's type, zero what the kind leaves undefined
  always_comb begin
    unique case (geom.vol_type)
      VOL_FAT12: tsel = 2'd0;
      VOL_FAT16: tsel = 2'd1;
      default:   tsel = 2'd2;
    endcase
    sect5_d = '0;
    boff5_d = '0;
    cls5_d  = CLS_FREE;
    nxt5_d  = '0;
    unique case (kind4_q)
      KIND_LOCATE: begin
        sect5_d = sect4_q[tsel];
        boff5_d = boff4_q[tsel];
      end
      KIND_CLASSIFY: begin
        cls5_d = cls4_q[tsel];
        nxt5_d = nxt4_q[tsel];
      end
      KIND_DATA: begin
        sect5_d = oor4_q ? '0 : dsec4_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind1_q <= kind_e'(kind_i);
    cl1_q   <= cluster_i;
    raw1_q  <= raw_entry_i;

    kind2_q <= kind1_q;
    cl2_q   <= cl1_q;
    off2_q  <= off_d;
    ent2_q  <= ent_d;

    kind3_q <= kind2_q;
    cl3_q   <= cl2_q;
    sect3_q <= sect_d;
    boff3_q <= boff_d;
    ent3_q  <= ent2_q;
    dsh3_q  <= dsh_d;

    kind4_q <= kind3_q;
    sect4_q <= sect3_q;
    boff4_q <= boff3_q;
    cls4_q  <= cls_d;
    nxt4_q  <= nxt_d;
    oor4_q  <= oor_d;
    dsec4_q <= dsec_d;

    sect5_q <= sect5_d;
    boff5_q <= boff5_d;
    cls5_q  <= cls5_d;
    nxt5_q  <= nxt5_d;
    type5_q <= geom.vol_type;
    oor5_q  <= oor4_q;
  end

  assign done_o          = v5_q;
  assign volume_type_o   = type5_q;
  assign sector_number_o = sect5_q;
  assign byte_offset_o   = boff5_q;
  assign entry_class_o   = cls5_q;
  assign next_cluster_o  = nxt5_q;
  assign out_of_range_o  = oor5_q;

endmodule

[src/fatd_chk.sv]
module fatd_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           cfg_we_i,
  input logic                           done_o,
  input logic [fatd_pkg::SectorW-1:0]   sector_number_o,
  input logic [fatd_pkg::OffsetW-1:0]   byte_offset_o,
  input logic [fatd_pkg::ClassW-1:0]    entry_class_o,
  input logic [fatd_pkg::ClusterW-1:0]  next_cluster_o
);
  import fatd_pkg::*;

  // every accepted item comes out with done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##5 done_o)
    else $error("accepted item produced no result");

  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result without an accepted item");

  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o)
    else $error("item port open while geometry re-derives");

  a_next_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && next_cluster_o != '0 |-> entry_class_o == CLS_NEXT)
    else $error("next cluster given for a non-next entry");

  // a nonzero class only comes from a classify item, which leaves the locate fields zero
  a_class_zero_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && entry_class_o != CLS_FREE |-> sector_number_o == '0 && byte_offset_o == '0)
    else $error("classify result carries sector fields");

endmodule

bind fat_table_entry_locate_decode fatd_chk u_fatd_chk (.*);

[sim/fat_table_entry_locate_decode_tb.sv]
`timescale 1ns / 1ps

import fatd_pkg::*;

typedef struct packed {
  vol_type_e           vol;
  logic [SectorW-1:0]  sector;
  logic [OffsetW-1:0]  offset;
  entry_class_e        cls;
  logic [ClusterW-1:0] next_cl;
  logic                oor;
} fat_answer_t;

class fat_answer_board;
  cfg_t        geom_regs;
  logic [31:0] cluster_total;
  logic [31:0] first_data_sector;
  vol_type_e   vol_type;
  fat_answer_t pending_answers[$];
  int unsigned mismatches;

  function new();
    geom_regs  = CfgReset;
    mismatches = 0;
    rederive();
  endfunction

  function int unsigned eff_sector_log2();
    if (geom_regs.sector_log2 < 4'd9) begin
      return 9;
    end
    if (geom_regs.sector_log2 > 4'd12) begin
      return 12;
    end
    return int'(geom_regs.sector_log2);
  endfunction

  function void rederive();
    int unsigned sl;
    logic [63:0] root_secs;
    logic [63:0] over;
    logic [63:0] data_secs;
    sl = eff_sector_log2();
    root_secs = (64'(geom_regs.root_entries) * 64'd32 + (64'd1 << sl) - 64'd1) >> sl;
    over = 64'(geom_regs.reserved)
         + 64'(geom_regs.fat_copies) * 64'(geom_regs.sectors_per_fat) + root_secs;
    // layout larger than the volume leaves no data sectors
    data_secs = (64'(geom_regs.total_sectors) > over) ?
                64'(geom_regs.total_sectors) - over : 64'd0;
    cluster_total = 32'(data_secs >> geom_regs.cluster_log2);
    if (cluster_total < Fat12Limit) begin
      vol_type = VOL_FAT12;
    end else if (cluster_total < Fat16Limit) begin
      vol_type = VOL_FAT16;
    end else begin
      vol_type = VOL_FAT32;
    end
    first_data_sector = (over > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : over[31:0];
  endfunction

  function void write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    case (idx)
      CFG_SECTOR_LOG2:     geom_regs.sector_log2     = value[3:0];
      CFG_CLUSTER_LOG2:    geom_regs.cluster_log2    = value[2:0];
      CFG_RESERVED:        geom_regs.reserved        = value[15:0];
      CFG_FAT_COPIES:      geom_regs.fat_copies      = value[7:0];
      CFG_SECTORS_PER_FAT: geom_regs.sectors_per_fat = value;
      CFG_ROOT_ENTRIES:    geom_regs.root_entries    = value[15:0];
      CFG_TOTAL_SECTORS:   geom_regs.total_sectors   = value;
      default:             return;
    endcase
    rederive();
  endfunction

  function fat_answer_t decode_request(input kind_e kind, input logic [ClusterW-1:0] cl,
                                       input logic [RawW-1:0] raw);
    fat_answer_t a;
    int unsigned sl;
    logic [63:0] off;
    logic [31:0] v;
    logic [31:0] base;
    logic [15:0] w;
    a     = '0;
    a.vol = vol_type;
    a.oor = (cl < 2) || (32'(cl) > cluster_total);
    sl    = eff_sector_log2();
    case (kind)
      KIND_LOCATE: begin
        case (vol_type)
          VOL_FAT12: off = 64'(cl) + 64'(cl >> 1);
          VOL_FAT16: off = 64'(cl) << 1;
          default:   off = 64'(cl) << 2;
        endcase
        a.sector = 32'(64'(geom_regs.reserved) + (off >> sl));
        a.offset = 12'(off & ((64'd1 << sl) - 64'd1));
      end
      KIND_CLASSIFY: begin
        w = raw[15:0];
        case (vol_type)
          VOL_FAT12: begin
            // odd clusters sit in the upper 12 bits of the word
            v    = 32'((cl[0] ? (w >> 4) : w) & 16'h0FFF);
            base = 32'(Base12);
          end
          VOL_FAT16: begin
            v    = 32'(w);
            base = 32'(Base16);
          end
          default: begin
            v    = raw & 32'h0FFF_FFFF;
            base = 32'(Base32);
          end
        endcase
        if (v == 0) begin
          a.cls = CLS_FREE;
        end else if (v >= 2 && 64'(v) <= 64'(cluster_total) + 64'd1 && v < base) begin
          a.cls     = CLS_NEXT;
          a.next_cl = v[ClusterW-1:0];
        end else if (v >= base && v <= base + 6) begin
          a.cls = CLS_RESERVED;
        end else if (v == base + 7) begin
          a.cls = CLS_BAD;
        end else if (v >= base + 8) begin
          a.cls = CLS_END;
        end else begin
          a.cls = CLS_INVALID;
        end
      end
      KIND_DATA: begin
        if (!a.oor) begin
          a.sector = 32'(64'(first_data_sector)
                       + (64'(32'(cl) - 32'd2) << geom_regs.cluster_log2));
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function void note_item(input kind_e kind, input logic [ClusterW-1:0] cl,
                          input logic [RawW-1:0] raw);
    pending_answers.push_back(decode_request(kind, cl, raw));
  endfunction

  function void compare_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  function void check_result(input logic [TypeW-1:0] vol, input logic [SectorW-1:0] sector,
                             input logic [OffsetW-1:0] offset, input logic [ClassW-1:0] cls,
                             input logic [ClusterW-1:0] next_cl, input logic oor);
    fat_answer_t want;
    if (pending_answers.size() == 0) begin
      mismatches++;
      $display("%0t: result with no item pending, expected none, got sector 0x%0h",
               $time, sector);
      return;
    end
    want = pending_answers.pop_front();
    compare_field("volume_type", 32'(want.vol), 32'(vol));
    compare_field("sector_number", want.sector, sector);
    compare_field("byte_offset", 32'(want.offset), 32'(offset));
    compare_field("entry_class", 32'(want.cls), 32'(cls));
    compare_field("next_cluster", 32'(want.next_cl), 32'(next_cl));
    compare_field("out_of_range", 32'(want.oor), 32'(oor));
  endfunction
endclass

module fat_table_entry_locate_decode_tb;
  import fatd_pkg::*;

  localparam int unsigned PhaseItems = 115;
  localparam int unsigned NumPhases  = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [KindW-1:0]    kind_i;
  logic [ClusterW-1:0] cluster_i;
  logic [RawW-1:0]     raw_entry_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                done_o;
  logic [TypeW-1:0]    volume_type_o;
  logic [SectorW-1:0]  sector_number_o;
  logic [OffsetW-1:0]  byte_offset_o;
  logic [ClassW-1:0]   entry_class_o;
  logic [ClusterW-1:0] next_cluster_o;
  logic                out_of_range_o;

  fat_answer_board board;

  fat_table_entry_locate_decode dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("fat_table_entry_locate_decode verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        board.check_result(volume_type_o, sector_number_o, byte_offset_o, entry_class_o,
                           next_cluster_o, out_of_range_o);
      end
      if (cfg_we_i) begin
        board.write_reg(cfg_idx_e'(cfg_idx_i), cfg_wdata_i);
      end
      if (start_i && !busy_o) begin
        board.note_item(kind_e'(kind_i), cluster_i, raw_entry_i);
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the item
  task automatic send_item(input kind_e kind, input logic [ClusterW-1:0] cl,
                           input logic [RawW-1:0] raw);
    start_i     <= 1'b1;
    kind_i      <= kind;
    cluster_i   <= cl;
    raw_entry_i <= raw;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_geometry_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic set_geometry(input logic [3:0] sl, input logic [2:0] clog,
                              input logic [15:0] rsv, input logic [7:0] fats,
                              input logic [31:0] spf, input logic [15:0] root,
                              input logic [31:0] total);
    write_geometry_reg(CFG_SECTOR_LOG2, 32'(sl));
    write_geometry_reg(CFG_CLUSTER_LOG2, 32'(clog));
    write_geometry_reg(CFG_RESERVED, 32'(rsv));
    write_geometry_reg(CFG_FAT_COPIES, 32'(fats));
    write_geometry_reg(CFG_SECTORS_PER_FAT, spf);
    write_geometry_reg(CFG_ROOT_ENTRIES, 32'(root));
    write_geometry_reg(CFG_TOTAL_SECTORS, total);
  endtask

  // stop sending, let every result come back, then allow for the pipeline depth
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_answers.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [ClusterW-1:0] pick_cluster();
    logic [31:0] top;
    top = (board.cluster_total >= 32'h0FFF_FFFE) ? 32'h0FFF_FFFF : board.cluster_total + 1;
    case ($urandom_range(0, 9))
      0:       return ClusterW'($urandom_range(0, 3));
      1:       return ClusterW'(top - $urandom_range(0, 1));
      2, 3:    return ClusterW'($urandom);
      default: return ClusterW'($urandom_range(0, top));
    endcase
  endfunction

  // mostly words whose entry lands on a class boundary of the current type
  function automatic logic [RawW-1:0] pick_raw(input logic [ClusterW-1:0] cl);
    logic [31:0] raw;
    logic [31:0] v;
    logic [31:0] base;
    logic [31:0] lim;
    logic [31:0] hi;
    raw = $urandom;
    case (board.vol_type)
      VOL_FAT12: begin
        base = 32'(Base12);
        lim  = 32'h0000_0FFF;
      end
      VOL_FAT16: begin
        base = 32'(Base16);
        lim  = 32'h0000_FFFF;
      end
      default: begin
        base = 32'(Base32);
        lim  = 32'h0FFF_FFFF;
      end
    endcase
    hi = (64'(board.cluster_total) + 64'd1 < 64'(lim)) ? board.cluster_total + 1 : lim;
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(0, 1);
      1, 2:    v = $urandom_range(2, hi);
      3, 4:    v = base + $urandom_range(0, 15);
      5:       v = $urandom_range(hi, lim);
      default: return raw;
    endcase
    case (board.vol_type)
      VOL_FAT12: begin
        if (cl[0]) begin
          raw[15:4] = v[11:0];
        end else begin
          raw[11:0] = v[11:0];
        end
      end
      VOL_FAT16: raw[15:0] = v[15:0];
      default:   raw[27:0] = v[27:0];
    endcase
    return raw;
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned burst;
    int unsigned drain_at;
    int unsigned r;
    kind_e kind;
    logic [ClusterW-1:0] cl;
    burst    = $urandom_range(1, 30);
    drain_at = $urandom_range(0, count - 1);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == drain_at) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while (board.pending_answers.size() != 0);
      end else if (burst == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 30);
      end
      if (burst > 0) begin
        burst--;
      end
      r = $urandom_range(0, 19);
      if (r < 6) begin
        kind = KIND_LOCATE;
      end else if (r < 13) begin
        kind = KIND_CLASSIFY;
      end else if (r < 19) begin
        kind = KIND_DATA;
      end else begin
        kind = KIND_NONE;
      end
      cl = pick_cluster();
      send_item(kind, cl, pick_raw(cl));
    end
  endtask

  initial begin
    board       = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    kind_i      = KIND_LOCATE;
    cluster_i   = '0;
    raw_entry_i = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_SECTOR_LOG2;
    cfg_wdata_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // boot geometry: FAT12, 2847 clusters, data from sector 33
    send_item(KIND_LOCATE, 0, 0);
    send_item(KIND_LOCATE, 1, 0);
    send_item(KIND_LOCATE, 3, 0);
    send_item(KIND_LOCATE, 2847, 0);
    send_item(KIND_LOCATE, '1, '1);
    send_item(KIND_CLASSIFY, 2, 32'h0000_0000);
    send_item(KIND_CLASSIFY, 3, 32'h0000_0010);
    send_item(KIND_CLASSIFY, 4, 32'hFFFF_F002);
    send_item(KIND_CLASSIFY, 5, 32'h0000_B200);
    send_item(KIND_CLASSIFY, 6, 32'h0000_0B21);
    send_item(KIND_CLASSIFY, 7, 32'h0000_FF00);
    send_item(KIND_CLASSIFY, 8, 32'h0000_0FF6);
    send_item(KIND_CLASSIFY, 9, 32'h0000_FF70);
    send_item(KIND_CLASSIFY, 10, 32'h0000_0FF8);
    send_item(KIND_CLASSIFY, '1, '1);
    send_item(KIND_DATA, 0, 0);
    send_item(KIND_DATA, 1, 0);
    send_item(KIND_DATA, 2, 0);
    send_item(KIND_DATA, 2847, 0);
    send_item(KIND_DATA, 2848, 0);
    send_item(KIND_DATA, '1, '1);
    send_item(KIND_NONE, 5, 32'hDEAD_BEEF);
    send_item(KIND_NONE, '1, '1);

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        settle();
      end
      case (p)
        0: ;
        1: set_geometry(4'd9, 3'd0, 16'd1, 8'd2, 32'd100, 16'd512, 32'd40000);
        2: set_geometry(4'd12, 3'd7, 16'd32, 8'd2, 32'd8000, 16'd0, 32'hFFFF_FFFF);
        // every field at its top: layout overflows, sector of data saturates
        3: set_geometry(4'd15, 3'd7, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        4: set_geometry(4'd0, 3'd0, 16'd0, 8'd1, 32'd0, 16'd0, 32'd0);
        // smallest FAT16 and smallest FAT32 cluster counts
        5: set_geometry(4'd9, 3'd0, 16'd0, 8'd0, 32'd123, 16'd0, 32'd4085);
        6: set_geometry(4'd10, 3'd0, 16'd0, 8'd0, 32'd0, 16'd0, 32'd65525);
        default: begin
          set_geometry(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), 16'($urandom),
                       8'($urandom),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096),
                       16'($urandom), $urandom >> $urandom_range(0, 20));
        end
      endcase
      run_random(PhaseItems);
    end

    settle();
    if (board.mismatches == 0 && board.pending_answers.size() == 0) begin
      $display("fat_table_entry_locate_decode verification clean");
    end else begin
      $display("fat_table_entry_locate_decode verification failed");
    end
    $finish;
  end

endmodule
